[hw/rtl/qstm_pkg.sv]
// shared widths, constants and helpers for the quaternion transform matrix block
`default_nettype none

package qstm_pkg;

  localparam int unsigned QUAT_W    = 16;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned TRANS_W   = 32;
  localparam int unsigned PROD_W    = 2 * QUAT_W;
  // 1 - 2(a+b) and 2(a+-b) over two Q2.30 products need two extra bits
  localparam int unsigned TERM_W    = PROD_W + 2;
  localparam int unsigned SCALED_W  = TERM_W + SCALE_W;
  localparam int unsigned ROUND_SH  = 22;
  localparam int unsigned ROUNDED_W = SCALED_W + 1 - ROUND_SH;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned NUM_TERMS = 9;

  localparam logic signed [TERM_W-1:0]   OneQ30    = TERM_W'(64'sd1 <<< 30);
  localparam logic signed [SCALED_W:0]   RoundBias = (SCALED_W + 1)'(64'sd1 <<< (ROUND_SH - 1));
  localparam logic signed [63:0]         OutMax    = 64'sd2147483647;
  localparam logic signed [63:0]         OutMin    = -64'sd2147483648;

  // per-stage load enables of one scaling lane
  typedef struct packed {
    logic mul_en;
    logic rnd_en;
  } lane_ctrl_t;

  function automatic logic [OUT_W-1:0] sat_q16(input logic signed [ROUNDED_W-1:0] v);
    logic signed [63:0] wide;
    wide = 64'(v);
    if (wide > OutMax) begin
      return OutMax[OUT_W-1:0];
    end else if (wide < OutMin) begin
      return OutMin[OUT_W-1:0];
    end
    return wide[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/quat_scale_to_transform_matrix_core.sv]
// Quaternion plus per-axis scale to a 4x3 transform matrix, four register stages.
// The block takes one transform per cycle while the output side is ready, and
// hands out its matrix from stage four: stage one forms the nine quaternion
// products, stage two the nine unscaled terms, stage three multiplies each
// term by its row's scale and stage four rounds to Q16.16 (half toward plus
// infinity) and saturates. Each stage holds its item while the stage behind it
// is full, so a stalled output side backs up stage by stage and up to four
// items sit in the block. Translation travels alongside unchanged as the fourth row.
`default_nettype none

module quat_scale_to_transform_matrix_core (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z, trans_x, trans_y, trans_z
  input  wire  [207:0]  s_axis_tdata_i,
  output logic          m_axis_tvalid_o,
  input  wire           m_axis_tready_i,
  // m11, m12, m13, m21, m22, m23, m31, m32, m33, row4_x, row4_y, row4_z
  output logic [383:0]  m_axis_tdata_o
);

  localparam int unsigned QW = qstm_pkg::QUAT_W;
  localparam int unsigned PW = qstm_pkg::PROD_W;
  localparam int unsigned TW = qstm_pkg::TERM_W;
  localparam int unsigned SW = qstm_pkg::SCALE_W;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic s_accept;

  assign rdy4 = !v4_q || m_axis_tready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready_o = rdy1;
  assign s_accept        = s_axis_tvalid_i && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // input unpacking
  logic signed [QW-1:0] qx, qy, qz, qw;
  assign qx = s_axis_tdata_i[15:0];
  assign qy = s_axis_tdata_i[31:16];
  assign qz = s_axis_tdata_i[47:32];
  assign qw = s_axis_tdata_i[63:48];

  // stage one: quaternion products in q2.30
  logic signed [PW-1:0] xx_d, yy_d, zz_d, xy_d, xz_d, yz_d, wx_d, wy_d, wz_d;
  logic signed [PW-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic [47:0] scale_s1_q, scale_s2_q;
  logic [95:0] trans_s1_q, trans_s2_q, trans_s3_q, trans_s4_q;

  assign xx_d = qx * qx;
  assign yy_d = qy * qy;
  assign zz_d = qz * qz;
  assign xy_d = qx * qy;
  assign xz_d = qx * qz;
  assign yz_d = qy * qz;
  assign wx_d = qw * qx;
  assign wy_d = qw * qy;
  assign wz_d = qw * qz;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      xx_q       <= xx_d;
      yy_q       <= yy_d;
      zz_q       <= zz_d;
      xy_q       <= xy_d;
      xz_q       <= xz_d;
      yz_q       <= yz_d;
      wx_q       <= wx_d;
      wy_q       <= wy_d;
      wz_q       <= wz_d;
      scale_s1_q <= s_axis_tdata_i[111:64];
      trans_s1_q <= s_axis_tdata_i[207:112];
    end
  end

  // stage two: unscaled matrix terms in q30
  logic signed [TW-1:0] term_d [qstm_pkg::NUM_TERMS];
  logic signed [TW-1:0] term_q [qstm_pkg::NUM_TERMS];

  function automatic logic signed [TW-1:0] ext(input logic signed [PW-1:0] p);
    return TW'(p);
  endfunction

  always_comb begin
    term_d[0] = qstm_pkg::OneQ30 - ((ext(yy_q) + ext(zz_q)) <<< 1);
    term_d[1] = (ext(xy_q) + ext(wz_q)) <<< 1;
    term_d[2] = (ext(xz_q) - ext(wy_q)) <<< 1;
    term_d[3] = (ext(xy_q) - ext(wz_q)) <<< 1;
    term_d[4] = qstm_pkg::OneQ30 - ((ext(xx_q) + ext(zz_q)) <<< 1);
    term_d[5] = (ext(yz_q) + ext(wx_q)) <<< 1;
    term_d[6] = (ext(xz_q) + ext(wy_q)) <<< 1;
    term_d[7] = (ext(yz_q) - ext(wx_q)) <<< 1;
    term_d[8] = qstm_pkg::OneQ30 - ((ext(xx_q) + ext(yy_q)) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      term_q     <= term_d;
      scale_s2_q <= scale_s1_q;
      trans_s2_q <= trans_s1_q;
    end
  end

  // stages three and four live in the lanes
  qstm_pkg::lane_ctrl_t lane_ctrl;
  assign lane_ctrl.mul_en = rdy3;
  assign lane_ctrl.rnd_en = rdy4;

  always_ff @(posedge clk_i) begin
    if (rdy3) trans_s3_q <= trans_s2_q;
    if (rdy4) trans_s4_q <= trans_s3_q;
  end

  for (genvar i = 0; i < qstm_pkg::NUM_TERMS; i++) begin : g_lane
    localparam int unsigned ROW = i / 3;
    logic [qstm_pkg::OUT_W-1:0] res;

    qstm_scale_lane u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (lane_ctrl),
      .term_i   (term_q[i]),
      .scale_i  ($signed(scale_s2_q[ROW*SW +: SW])),
      .result_o (res)
    );

    assign m_axis_tdata_o[i*qstm_pkg::OUT_W +: qstm_pkg::OUT_W] = res;
  end

  assign m_axis_tdata_o[383:288] = trans_s4_q;
  assign m_axis_tvalid_o         = v4_q;

  // an empty first stage must always take an item
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> s_axis_tready_o) else $error("stage one empty but not ready");

  // an accepted item lands in stage one
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> v1_q) else $error("accepted item lost at stage one");

  // a blocked stage three keeps its item and its translation
  a_stage3_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !rdy4) |=> (v3_q && $stable(trans_s3_q)))
    else $error("stage three dropped a stalled item");

  // stage four only fills from a valid stage three
  a_stage4_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!v4_q && !v3_q) |=> !v4_q) else $error("stage four filled from a bubble");

endmodule

`default_nettype wire

[hw/rtl/qstm_scale_lane.sv]
// one matrix entry: term times scale, then round to q16.16 and saturate
`default_nettype none

module qstm_scale_lane (
  input  wire                                 clk_i,
  input  wire qstm_pkg::lane_ctrl_t           ctrl_i,
  input  wire logic signed [qstm_pkg::TERM_W-1:0]  term_i,
  input  wire logic signed [qstm_pkg::SCALE_W-1:0] scale_i,
  output logic [qstm_pkg::OUT_W-1:0]          result_o
);

  logic signed [qstm_pkg::SCALED_W-1:0] scaled_d, scaled_q;
  logic signed [qstm_pkg::SCALED_W:0]   biased;
  logic signed [qstm_pkg::ROUNDED_W-1:0] rounded;
  logic [qstm_pkg::OUT_W-1:0]           result_d, result_q;

  assign scaled_d = term_i * scale_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      scaled_q <= scaled_d;
    end
  end

  // add half an lsb, then floor by dropping the low bits
  assign biased   = {scaled_q[qstm_pkg::SCALED_W-1], scaled_q} + qstm_pkg::RoundBias;
  assign rounded  = biased[qstm_pkg::SCALED_W:qstm_pkg::ROUND_SH];
  assign result_d = qstm_pkg::sat_q16(rounded);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rnd_en) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire
